[rtl/core/mbps_pkg.sv]
// masked byte pattern search: shared types and constants
// used by every module of the block, no dependencies
`timescale 1ns / 1ps

package mbps_pkg;

   localparam int DATA_W        = 8;
   localparam int ADDR_W        = 64;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;
   localparam int LEN_W         = 6;
   localparam int CARE_W        = 32;
   localparam int PATTERN_WORDS = 4;
   localparam int PATTERN_BYTES = 32;
   localparam int BYTE_SEL_W    = 5;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_WORD_0 = 3'd0,
      CSR_PATTERN_WORD_1 = 3'd1,
      CSR_PATTERN_WORD_2 = 3'd2,
      CSR_PATTERN_WORD_3 = 3'd3,
      CSR_CARE_MASK      = 3'd4,
      CSR_PATTERN_LENGTH = 3'd5,
      CSR_BASE_ADDRESS   = 3'd6
   } mbps_csr_type;

   // derived configuration handed from the register file to the compare stage
   typedef struct packed {
      logic              len_ok;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] bias;
   } mbps_cfg_type;

   // one request held in the window stage
   typedef struct packed {
      logic              valid;
      logic              last;
      logic [ADDR_W-1:0] count;
   } mbps_slot_type;

endpackage

[rtl/core/mbps_cfg_regs.sv]
// masked byte pattern search: configuration registers and pattern alignment
// depends on mbps_pkg
`timescale 1ns / 1ps

module mbps_cfg_regs #(
   parameter int MAX_PATTERN_BYTES = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_write_en,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]             csr_wdata,
   output logic [MAX_PATTERN_BYTES-1:0][mbps_pkg::DATA_W-1:0] eff_pattern,
   output logic [MAX_PATTERN_BYTES-1:0]                eff_care,
   output mbps_pkg::mbps_cfg_type                      cfg
);
   import mbps_pkg::*;

   logic [PATTERN_WORDS-1:0][CSR_DATA_W-1:0] pattern_ff, pattern_in;
   logic [CARE_W-1:0]                        care_ff, care_in;
   logic [LEN_W-1:0]                         len_ff, len_in;
   logic [ADDR_W-1:0]                        base_ff, base_in;

   logic [MAX_PATTERN_BYTES-1:0][DATA_W-1:0] eff_pattern_ff, eff_pattern_in;
   logic [MAX_PATTERN_BYTES-1:0]             eff_care_ff, eff_care_in;
   mbps_cfg_type                             cfg_ff, cfg_in;

   logic [PATTERN_BYTES-1:0][DATA_W-1:0]     pattern_bytes;

   always_comb begin
      pattern_in = pattern_ff;
      care_in    = care_ff;
      len_in     = len_ff;
      base_in    = base_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_PATTERN_WORD_0: pattern_in[0] = csr_wdata;
            CSR_PATTERN_WORD_1: pattern_in[1] = csr_wdata;
            CSR_PATTERN_WORD_2: pattern_in[2] = csr_wdata;
            CSR_PATTERN_WORD_3: pattern_in[3] = csr_wdata;
            CSR_CARE_MASK:      care_in       = csr_wdata[CARE_W-1:0];
            CSR_PATTERN_LENGTH: len_in        = csr_wdata[LEN_W-1:0];
            CSR_BASE_ADDRESS:   base_in       = csr_wdata;
            default: ;
         endcase
      end
   end

   assign pattern_bytes = pattern_ff;

   // pattern reversed so that position j lines up with window entry j
   always_comb begin
      logic [LEN_W-1:0] idx;
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         idx               = len_ff - LEN_W'(1) - LEN_W'(j);
         eff_pattern_in[j] = pattern_bytes[idx[BYTE_SEL_W-1:0]];
         eff_care_in[j]    = (LEN_W'(j) < len_ff) && care_ff[idx[BYTE_SEL_W-1:0]];
      end
      cfg_in.len_ok = (len_ff != '0) && (len_ff <= LEN_W'(MAX_PATTERN_BYTES));
      cfg_in.len    = len_ff;
      cfg_in.bias   = base_ff - ADDR_W'(len_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff     <= '0;
         care_ff        <= '0;
         len_ff         <= '0;
         base_ff        <= '0;
         eff_pattern_ff <= '0;
         eff_care_ff    <= '0;
         cfg_ff         <= '0;
      end else begin
         pattern_ff     <= pattern_in;
         care_ff        <= care_in;
         len_ff         <= len_in;
         base_ff        <= base_in;
         eff_pattern_ff <= eff_pattern_in;
         eff_care_ff    <= eff_care_in;
         cfg_ff         <= cfg_in;
      end
   end

   assign eff_pattern = eff_pattern_ff;
   assign eff_care    = eff_care_ff;
   assign cfg         = cfg_ff;

endmodule

[rtl/core/mbps_window.sv]
// masked byte pattern search: input stage, byte window and region byte count
// depends on mbps_pkg
`timescale 1ns / 1ps

module mbps_window #(
   parameter int MAX_PATTERN_BYTES = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic [mbps_pkg::DATA_W-1:0]                 req_data_byte,
   input  logic                                        req_region_last,
   input  logic                                        slot_take,
   output mbps_pkg::mbps_slot_type                     slot,
   output logic [MAX_PATTERN_BYTES-1:0][mbps_pkg::DATA_W-1:0] window
);
   import mbps_pkg::*;

   logic [MAX_PATTERN_BYTES-1:0][DATA_W-1:0] window_ff, window_in;
   logic                                     valid_ff, valid_in;
   logic                                     last_ff, last_in;
   logic [ADDR_W-1:0]                        count_ff, count_in;
   logic [ADDR_W-1:0]                        offset;
   logic                                     accept;

   assign req_ready = !valid_ff || slot_take;
   assign accept    = req_valid && req_ready;

   // bytes already seen in this region; a region ends at its last byte
   assign offset = last_ff ? '0 : count_ff;

   always_comb begin
      window_in = window_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      valid_in  = valid_ff && !slot_take;
      if (accept) begin
         for (int j = MAX_PATTERN_BYTES - 1; j > 0; j--) begin
            window_in[j] = window_ff[j-1];
         end
         window_in[0] = req_data_byte;
         last_in      = req_region_last;
         count_in     = (&offset) ? offset : offset + ADDR_W'(1);
         valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         valid_ff  <= 1'b0;
         last_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         window_ff <= window_in;
         valid_ff  <= valid_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
      end
   end

   assign slot.valid = valid_ff;
   assign slot.last  = last_ff;
   assign slot.count = count_ff;
   assign window     = window_ff;

endmodule

[rtl/core/mbps_match.sv]
// masked byte pattern search: parallel masked compare and result register
// depends on mbps_pkg
`timescale 1ns / 1ps

module mbps_match #(
   parameter int MAX_PATTERN_BYTES = 32
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  mbps_pkg::mbps_slot_type                     slot,
   input  logic [MAX_PATTERN_BYTES-1:0][mbps_pkg::DATA_W-1:0] window,
   input  logic [MAX_PATTERN_BYTES-1:0][mbps_pkg::DATA_W-1:0] eff_pattern,
   input  logic [MAX_PATTERN_BYTES-1:0]                eff_care,
   input  mbps_pkg::mbps_cfg_type                      cfg,
   output logic                                        slot_take,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic                                        rsp_found,
   output logic [mbps_pkg::ADDR_W-1:0]                 rsp_match_address
);
   import mbps_pkg::*;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      found_ff, found_in;
   logic [ADDR_W-1:0]         address_ff, address_in;
   logic                      done_ff, done_in;

   logic [MAX_PATTERN_BYTES-1:0] byte_ok;
   logic                      hit;
   logic                      report;

   always_comb begin
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         byte_ok[j] = !eff_care[j] || (window[j] == eff_pattern[j]);
      end
   end

   assign hit       = cfg.len_ok && (slot.count >= ADDR_W'(cfg.len)) && (&byte_ok);
   assign report    = !done_ff && (hit || slot.last);
   assign slot_take = slot.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      address_in   = address_ff;
      done_in      = done_ff;
      if (slot_take) begin
         if (report) begin
            rsp_valid_in = 1'b1;
            found_in     = hit;
            address_in   = hit ? cfg.bias + slot.count : '0;
         end
         done_in = slot.last ? 1'b0 : (done_ff || hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff   <= found_in;
      address_ff <= address_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_match_address = address_ff;

endmodule

[rtl/core/masked_byte_pattern_search.sv]
// masked byte pattern search: top level
// depends on mbps_pkg, mbps_cfg_regs, mbps_window, mbps_match
`timescale 1ns / 1ps

// usage
//  - req_ channel carries the bytes of a region, one per request; req_region_last
//    marks the final byte, after which the next byte starts a new region
//  - rsp_ channel gives at most one response per region: found with
//    base_address plus match offset at the byte that completes the first match,
//    or not-found (address zero) at the region's last byte
//  - csr_ port writes pattern words, care mask, pattern length and base
//    address; write only while no request is in flight
//  - an accepted request is held in the window register, and its response is
//    registered in the response register once that register is free to take it
//  - throughput: one request per cycle while rsp_ready does not stall, set by the
//    single compare stage between the window register and the response register
//  - a stalled rsp_ready holds the response; one more request is still taken
//    into the window stage, after which req_ready drops until the response drains
//  - reset clears the configuration, the window and the region state

module masked_byte_pattern_search #(
   parameter int MAX_PATTERN_BYTES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mbps_pkg::DATA_W-1:0]        req_data_byte,
   input  logic                               req_region_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [mbps_pkg::ADDR_W-1:0]        rsp_match_address
);
   import mbps_pkg::*;

   // pattern aligned to window order, re-registered from the stored pattern after each write
   logic [MAX_PATTERN_BYTES-1:0][DATA_W-1:0] eff_pattern;
   logic [MAX_PATTERN_BYTES-1:0]             eff_care;
   mbps_cfg_type                             cfg;

   // window stage contents and hand-off to the compare stage
   mbps_slot_type                            slot;
   logic [MAX_PATTERN_BYTES-1:0][DATA_W-1:0] window;
   logic                                     slot_take;

   mbps_cfg_regs #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_cfg_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .eff_pattern  (eff_pattern),
      .eff_care     (eff_care),
      .cfg          (cfg)
   );

   // shifts each accepted byte in and counts bytes of the current region
   mbps_window #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_window (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_region_last (req_region_last),
      .slot_take       (slot_take),
      .slot            (slot),
      .window          (window)
   );

   // compares every window byte at once and keeps the per-region done flag
   mbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_match (
      .clock             (clock),
      .reset             (reset),
      .slot              (slot),
      .window            (window),
      .eff_pattern       (eff_pattern),
      .eff_care          (eff_care),
      .cfg               (cfg),
      .slot_take         (slot_take),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address)
   );

endmodule

[sim/masked_byte_pattern_search_tb.sv]
// masked byte pattern search: self-checking testbench with driver, monitor and predictor
// depends on mbps_pkg and the masked_byte_pattern_search top level
`timescale 1ns / 1ps

module masked_byte_pattern_search_tb;
   import mbps_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 4;        // response register sits behind the window register
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 700;
   localparam int HOLD_PHASE = 6;
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 3'd7;
   localparam logic [DATA_W-1:0] WILDCARD_CHAR = 8'h3F;   // '?'

   typedef struct {
      logic [DATA_W-1:0] data;
      logic              last;
   } byte_req_type;

   typedef struct {
      logic              found;
      logic [ADDR_W-1:0] addr;
   } search_result_type;

   // receiver stall patterns
   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_SPARSE,
      RX_ALTERNATE
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [DATA_W-1:0] req_data_byte = '0;
   logic req_region_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_found;
   logic [ADDR_W-1:0] rsp_match_address;

   masked_byte_pattern_search uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_region_last   (req_region_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // shadow of the block: configuration and search state
   // ---------------------------------------------------------------------
   logic [8*PATTERN_BYTES-1:0] pattern_bits = '0;   // byte i at bits 8i+7..8i
   logic [CARE_W-1:0]          care_bits = '0;
   logic [LEN_W-1:0]           pat_len = '0;
   logic [ADDR_W-1:0]          base_addr = '0;
   logic [DATA_W-1:0]          window [PATTERN_BYTES];  // entry 0 is the newest byte
   logic [ADDR_W-1:0]          region_offset = '0;
   logic                       region_reported = 1'b0;

   byte_req_type      pending_bytes [$];     // requests waiting for the driver
   search_result_type expected_results [$];  // responses still owed by the block

   int error_count = 0;
   int cycle_count = 0;
   int random_items = 0;

   initial begin
      for (int i = 0; i < PATTERN_BYTES; i++) window[i] = '0;
   end

   task automatic flag_error(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // advance the shadow search by one accepted byte and queue any response it owes
   function automatic void search_byte(input logic [DATA_W-1:0] data, input logic last);
      logic [ADDR_W-1:0] count;
      logic hit;
      int len;
      search_result_type res;
      for (int i = PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = data;
      count = region_offset;
      if (count != '1) count = count + 1'b1;   // offset saturates
      len = pat_len;
      if (!region_reported) begin
         hit = 1'b0;
         // lengths of zero or above the window never match
         if (len >= 1 && len <= PATTERN_BYTES && count >= ADDR_W'(len)) begin
            hit = 1'b1;
            for (int i = 0; i < len; i++) begin
               if (care_bits[i] && window[len-1-i] != pattern_bits[8*i +: 8]) hit = 1'b0;
            end
         end
         if (hit) begin
            res.found = 1'b1;
            res.addr = base_addr + (count - ADDR_W'(len));   // wraps modulo 2^64
            expected_results.insert(expected_results.size(), res);
            region_reported = 1'b1;
         end else if (last) begin
            res.found = 1'b0;
            res.addr = '0;
            expected_results.insert(expected_results.size(), res);
         end
      end
      if (last) begin
         region_offset = '0;
         region_reported = 1'b0;
      end else begin
         region_offset = count;
      end
   endfunction

   // ---------------------------------------------------------------------
   // request driver: bursts of random length with random gaps
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left = 0;
   byte_req_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) search_byte(req_data_byte, req_region_last);
         if (req_valid && !req_ready) begin
            // request still on offer, payload held
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            next_req = pending_bytes.pop_front();
            req_data_byte <= next_req.data;
            req_region_last <= next_req.last;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 32);
               case ($urandom_range(0, 4))
                  0, 1: gap_left = 0;
                  2, 3: gap_left = $urandom_range(1, 4);
                  default: gap_left = $urandom_range(5, 20);
               endcase
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // response receiver: changing stall patterns, plus one long hold-off
   // ---------------------------------------------------------------------
   rx_mode_type rx_mode = RX_OPEN;
   int rx_mode_left = 0;
   int hold_left = 0;
   logic hold_toggle = 1'b0;    // flipped by the stimulus to ask for a long hold
   logic hold_seen = 1'b0;
   logic next_ready;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
         rx_mode_left = 0;
      end else begin
         if (hold_seen != hold_toggle) begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               rx_mode_left = $urandom_range(5, 60);
            end
            rx_mode_left--;
            case (rx_mode)
               RX_OPEN:   next_ready = 1'b1;
               RX_COIN:   next_ready = 1'($urandom_range(0, 1));
               RX_SPARSE: next_ready = ($urandom_range(0, 3) == 0);
               default:   next_ready = ~rsp_ready;
            endcase
         end
         rsp_ready <= next_ready;
      end
   end

   // ---------------------------------------------------------------------
   // response monitor: compare against the oldest expected response
   // ---------------------------------------------------------------------
   search_result_type owed;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            flag_error($sformatf("response found=%0b addr=%h with none expected",
                                 rsp_found, rsp_match_address));
         end else begin
            owed = expected_results.pop_front();
            if (rsp_found !== owed.found)
               flag_error($sformatf("found %b, expected %b", rsp_found, owed.found));
            if (rsp_match_address !== owed.addr)
               flag_error($sformatf("match_address %h, expected %h",
                                    rsp_match_address, owed.addr));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   // one register write; only called while nothing is in flight
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_PATTERN_WORD_0: pattern_bits[0   +: 64] = val;
         CSR_PATTERN_WORD_1: pattern_bits[64  +: 64] = val;
         CSR_PATTERN_WORD_2: pattern_bits[128 +: 64] = val;
         CSR_PATTERN_WORD_3: pattern_bits[192 +: 64] = val;
         CSR_CARE_MASK:      care_bits = val[CARE_W-1:0];
         CSR_PATTERN_LENGTH: pat_len = val[LEN_W-1:0];
         CSR_BASE_ADDRESS:   base_addr = val;
         default: ;   // unmapped index, ignored
      endcase
   endtask

   // wait until every request is taken and every response is in, then let the pipe drain
   task automatic settle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_byte(input logic [DATA_W-1:0] data, input logic last);
      byte_req_type r;
      r.data = data;
      r.last = last;
      pending_bytes.insert(pending_bytes.size(), r);
   endtask

   // queue a region of n bytes, optionally with the current pattern planted in it
   task automatic queue_region(input int n, input bit plant, input bit close);
      logic [DATA_W-1:0] region_bytes [$];
      int at;
      int k;
      int len;
      len = pat_len;
      for (int i = 0; i < n; i++) begin
         // background mixes full-range noise with pattern bytes for near misses
         if ($urandom_range(0, 2) == 0) begin
            region_bytes.insert(region_bytes.size(), DATA_W'($urandom_range(0, 255)));
         end else begin
            k = $urandom_range(0, PATTERN_BYTES - 1);
            region_bytes.insert(region_bytes.size(), pattern_bits[8*k +: 8]);
         end
      end
      if (plant && len >= 1 && len <= PATTERN_BYTES && n >= len) begin
         at = $urandom_range(0, n - len);
         for (int i = 0; i < len; i++)
            if (care_bits[i]) region_bytes[at+i] = pattern_bits[8*i +: 8];
      end
      for (int i = 0; i < n; i++) push_byte(region_bytes[i], close && (i == n - 1));
   endtask

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   int phase;
   int phase_items;
   int phase_target;
   int n;
   int len_pick;
   logic [CSR_DATA_W-1:0] word;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // zero pattern length after reset: region always ends not-found
      @(negedge clock);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h00, 1'b1);
      settle();

      // "AB?D" with the third byte a wildcard
      write_reg(CSR_PATTERN_WORD_0, {32'h0, 8'h44, WILDCARD_CHAR, 8'h42, 8'h41});
      write_reg(CSR_PATTERN_WORD_1, {$urandom, $urandom});
      write_reg(CSR_PATTERN_WORD_2, '1);
      write_reg(CSR_PATTERN_WORD_3, '0);
      write_reg(CSR_CARE_MASK, 64'hFFFF_FFFF_0000_000B);    // upper bits fall away
      write_reg(CSR_PATTERN_LENGTH, 64'd4);
      write_reg(CSR_BASE_ADDRESS, 64'h1000);
      write_reg(CSR_NO_REGISTER, '1);                      // unmapped, no effect
      @(negedge clock);
      // match at offset zero, the rest of the region stays silent
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b0);
      push_byte(8'h99, 1'b0);
      push_byte(8'h44, 1'b0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h44, 1'b1);
      // region shorter than the pattern
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b1);
      // match completed by the last byte gives only the found response
      push_byte(8'h10, 1'b0);
      push_byte(8'h41, 1'b0);
      push_byte(8'h42, 1'b0);
      push_byte(WILDCARD_CHAR, 1'b0);
      push_byte(8'h44, 1'b1);
      settle();

      // address wrap past all ones
      write_reg(CSR_PATTERN_WORD_0, 64'hA55A);
      write_reg(CSR_CARE_MASK, 64'h3);
      write_reg(CSR_PATTERN_LENGTH, 64'd2);
      write_reg(CSR_BASE_ADDRESS, '1);
      @(negedge clock);
      push_byte(8'h00, 1'b0);
      push_byte(8'h5A, 1'b0);
      push_byte(8'hA5, 1'b1);
      settle();

      // length beyond the window never matches
      write_reg(CSR_PATTERN_LENGTH, 64'd40);
      @(negedge clock);
      push_byte(8'h5A, 1'b0);
      push_byte(8'hA5, 1'b1);

      // random phases; a phase may end mid-region so writes land inside one
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase++;
         settle();

         for (int r = 0; r < PATTERN_WORDS; r++) begin
            if ($urandom_range(0, 9) < 7) begin
               case ($urandom_range(0, 7))
                  0: word = '0;
                  1: word = '1;
                  default: word = {$urandom, $urandom};
               endcase
               write_reg(CSR_INDEX_W'(CSR_PATTERN_WORD_0 + r), word);
            end
         end
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 5))
               0: word = '0;
               1: word = {32'h0, 32'hFFFF_FFFF};
               2: word = {$urandom, $urandom};   // junk above the mask
               default: word = {32'h0, $urandom};
            endcase
            write_reg(CSR_CARE_MASK, word);
         end
         if (phase == 1 || $urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 19))
               0: len_pick = 0;
               1: len_pick = PATTERN_BYTES;
               2: len_pick = $urandom_range(PATTERN_BYTES + 1, 63);
               3, 4, 5: len_pick = $urandom_range(9, PATTERN_BYTES - 1);
               default: len_pick = $urandom_range(1, 8);
            endcase
            word = {$urandom, $urandom};
            if ($urandom_range(0, 9) < 7) word = '0;
            word[LEN_W-1:0] = LEN_W'(len_pick);
            write_reg(CSR_PATTERN_LENGTH, word);
         end
         if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 4))
               0: word = '0;
               1: word = '1;
               2: word = 64'hFFFF_FFFF_FFFF_FFF0;
               default: word = {$urandom, $urandom};
            endcase
            write_reg(CSR_BASE_ADDRESS, word);
         end
         if ($urandom_range(0, 9) == 0) write_reg(CSR_NO_REGISTER, {$urandom, $urandom});

         @(negedge clock);
         if (phase == HOLD_PHASE) begin
            // every region matches on its first byte; the receiver then holds off
            // while the sender keeps offering, so the block backs up
            write_reg(CSR_CARE_MASK, '0);
            write_reg(CSR_PATTERN_LENGTH, 64'd1);
            @(negedge clock);
            hold_toggle = ~hold_toggle;
            for (int r = 0; r < 60; r++) begin
               n = $urandom_range(1, 3);
               queue_region(n, 1'b0, 1'b1);
               random_items += n;
            end
         end else begin
            phase_items = 0;
            phase_target = $urandom_range(20, 50);
            while (phase_items < phase_target) begin
               len_pick = pat_len;
               if (len_pick >= 1 && len_pick <= PATTERN_BYTES && $urandom_range(0, 4) != 0)
                  n = $urandom_range(1, len_pick + 12);
               else
                  n = $urandom_range(1, 12);
               phase_items += n;
               // last region of a phase is often left open across the next writes
               queue_region(n, $urandom_range(0, 9) < 7,
                            (phase_items < phase_target) ? ($urandom_range(0, 19) != 0)
                                                         : ($urandom_range(0, 1) == 1));
            end
            random_items += phase_items;
         end
      end

      // close any open region so its response is owed, then drain
      settle();
      @(negedge clock);
      push_byte(DATA_W'($urandom_range(0, 255)), 1'b1);
      settle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/mbps_pkg.sv
rtl/core/mbps_cfg_regs.sv
rtl/core/mbps_window.sv
rtl/core/mbps_match.sv
rtl/core/masked_byte_pattern_search.sv
sim/masked_byte_pattern_search_tb.sv
